>>> hw/rtl/cldn_pkg.sv
package cldn_pkg;

    // number of decimal digits shown and the binary width that covers them
    localparam int DIGITS   = 5;
    localparam int BIN_W    = 17;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int SHIFTS   = BIN_W;
    localparam int IDX_W    = 4;
    localparam int NDIG_W   = 3;

    // values 0 up to DIGIT_LIMIT - 1 produce digits
    localparam logic [31:0] DIGIT_LIMIT = 32'd100000;

    // upper nibble of an ascii digit (0x30 + digit)
    localparam logic [3:0] ASCII_ZERO_HI = 4'h3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic             load;
        logic             shift;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic last;
    } sts_t;

endpackage

>>> hw/rtl/char_lcd_decimal_number_writer.sv
// Character LCD decimal number writer, 4-bit bus.
// Input channel (s_valid/s_ready): one request holds a cursor position byte
// and a signed 32-bit number. Output channel (m_valid/m_ready): one nibble
// transfer per handshake with register select, upper-half flag and a last
// flag on the final nibble of the request.
// The position goes out first as a command byte (reg select 0), then the
// decimal digits of 0..99999 as ascii bytes (reg select 1), no leading
// zeros, upper nibble before lower. Other values give the command only.
// The request is taken while idle; a binary-to-bcd shift loop runs, then the
// first nibble is shown. A request yields 2 to 12 nibbles, one per cycle
// while m_ready is high.
// s_ready is high only while idle; the next request is taken in the cycle
// after the last nibble is accepted.
// Reset (aresetn low, synchronous) returns to idle and drops m_valid.
// A receiver stall holds the current nibble and its flags steady.
module char_lcd_decimal_number_writer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_position,
    input  logic signed [31:0] s_number,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_nibble,
    output logic               m_reg_select,
    output logic               m_high_half,
    output logic               m_last
);

    cldn_pkg::cmd_t cmd;
    cldn_pkg::sts_t sts;

    cldn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    cldn_datapath u_datapath (
        .aclk         (aclk),
        .s_position   (s_position),
        .s_number     (s_number),
        .cmd          (cmd),
        .sts          (sts),
        .m_nibble     (m_nibble),
        .m_reg_select (m_reg_select),
        .m_high_half  (m_high_half),
        .m_last       (m_last)
    );

endmodule

>>> hw/rtl/cldn_datapath.sv
module cldn_datapath (
    input  logic                aclk,
    input  logic [7:0]          s_position,
    input  logic signed [31:0]  s_number,
    input  cldn_pkg::cmd_t      cmd,
    output cldn_pkg::sts_t      sts,
    output logic [3:0]          m_nibble,
    output logic                m_reg_select,
    output logic                m_high_half,
    output logic                m_last
);

    logic [7:0]                    pos_reg;
    logic [cldn_pkg::BIN_W-1:0]    bin_reg;
    logic [cldn_pkg::BCD_W-1:0]    bcd_reg;
    logic                          in_range_reg;

    logic [cldn_pkg::BCD_W-1:0]    bcd_adj;
    logic                          in_range;
    logic [cldn_pkg::NDIG_W-1:0]   ndig;
    logic [cldn_pkg::NDIG_W-1:0]   sel;
    logic [3:0]                    digit;
    logic [cldn_pkg::IDX_W-1:0]    last_idx;

    // range check of the incoming value
    assign in_range = !s_number[31] && ($unsigned(s_number) < cldn_pkg::DIGIT_LIMIT);

    // add-3 correction on every bcd digit of 5 or more before the shift
    always_comb begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < cldn_pkg::DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    // capture request, then shift binary into bcd one bit a cycle
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pos_reg      <= s_position;
            bin_reg      <= s_number[cldn_pkg::BIN_W-1:0];
            bcd_reg      <= '0;
            in_range_reg <= in_range;
        end else if (cmd.shift) begin
            bcd_reg <= {bcd_adj[cldn_pkg::BCD_W-2:0], bin_reg[cldn_pkg::BIN_W-1]};
            bin_reg <= {bin_reg[cldn_pkg::BIN_W-2:0], 1'b0};
        end
    end

    // digit count with leading zeros suppressed, at least one
    always_comb begin
        if (bcd_reg[19:16] != 4'd0) begin
            ndig = 3'd5;
        end else if (bcd_reg[15:12] != 4'd0) begin
            ndig = 3'd4;
        end else if (bcd_reg[11:8] != 4'd0) begin
            ndig = 3'd3;
        end else if (bcd_reg[7:4] != 4'd0) begin
            ndig = 3'd2;
        end else begin
            ndig = 3'd1;
        end
    end

    // digit for the current byte, most significant first
    assign sel = ndig - cmd.idx[cldn_pkg::IDX_W-1:1];

    always_comb begin
        unique case (sel)
            3'd0:    digit = bcd_reg[3:0];
            3'd1:    digit = bcd_reg[7:4];
            3'd2:    digit = bcd_reg[11:8];
            3'd3:    digit = bcd_reg[15:12];
            3'd4:    digit = bcd_reg[19:16];
            default: digit = 4'd0;
        endcase
    end

    // index of the final nibble of this request
    assign last_idx = in_range_reg ? {ndig, 1'b1} : 4'd1;
    assign sts.last = (cmd.idx == last_idx);

    // nibble selection from the transfer index
    always_comb begin
        if (cmd.idx[cldn_pkg::IDX_W-1:1] == 3'd0) begin
            m_nibble = cmd.idx[0] ? pos_reg[3:0] : pos_reg[7:4];
        end else begin
            m_nibble = cmd.idx[0] ? digit : cldn_pkg::ASCII_ZERO_HI;
        end
    end

    assign m_reg_select = (cmd.idx[cldn_pkg::IDX_W-1:1] != 3'd0);
    assign m_high_half  = !cmd.idx[0];
    assign m_last       = sts.last;

endmodule

>>> hw/rtl/cldn_ctrl.sv
module cldn_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output cldn_pkg::cmd_t cmd,
    input  cldn_pkg::sts_t sts
);

    localparam int CNT_W = $clog2(cldn_pkg::SHIFTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SEND
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [cldn_pkg::IDX_W-1:0] idx_reg;
    logic                       m_valid_reg;

    // state, shift counter, transfer index and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_CONVERT;
                        cnt_reg   <= '0;
                        idx_reg   <= '0;
                    end
                end
                ST_CONVERT: begin
                    if (cnt_reg == CNT_W'(cldn_pkg::SHIFTS - 1)) begin
                        state_reg   <= ST_SEND;
                        m_valid_reg <= 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SEND: begin
                    if (m_ready) begin
                        if (sts.last) begin
                            state_reg   <= ST_IDLE;
                            m_valid_reg <= 1'b0;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // handshake and datapath commands
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign cmd.load  = (state_reg == ST_IDLE) && s_valid;
    assign cmd.shift = (state_reg == ST_CONVERT);
    assign cmd.idx   = idx_reg;

    // checks
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= 4'd11)
        else $error("transfer index beyond twelve nibbles");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONVERT) |-> (cnt_reg <= CNT_W'(cldn_pkg::SHIFTS - 1)))
        else $error("shift counter overrun");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && sts.last) |=> (s_ready && !m_valid))
        else $error("block not idle after final nibble");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CONVERT && cnt_reg == '0 && idx_reg == '0))
        else $error("conversion did not start after request");

endmodule

>>> bench/char_lcd_decimal_number_writer_test.sv
`timescale 1ns / 1ps

module char_lcd_decimal_number_writer_test;

    localparam int DIGIT_LIMIT   = 100000;
    localparam int RANDOM_ITEMS  = 152;
    localparam int N_DIRECTED    = 18;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;

    // one nibble transfer on the lcd bus
    typedef struct packed {
        logic [3:0] nibble;
        logic       reg_select;
        logic       high_half;
        logic       last;
    } lcd_transfer_t;

    // directed row: byte_count of 0 means the predictor works it out,
    // otherwise byte_list holds the bytes in send order, first in the top byte
    typedef struct {
        logic [7:0]         position;
        logic signed [31:0] number;
        int                 byte_count;
        logic [47:0]        byte_list;
    } directed_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_position;
    logic signed [31:0] s_number;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_nibble;
    logic               m_reg_select;
    logic               m_high_half;
    logic               m_last;

    lcd_transfer_t expected_transfers[$];
    int            mismatch_count = 0;
    int            idle_cycles    = 0;
    bit            calm           = 1'b0;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{8'h80, 32'sd0,           2, 48'h8030_0000_0000},
        '{8'hFF, 32'sd99999,       6, 48'hFF39_3939_3939},
        '{8'h00, 32'sd100000,      1, 48'h0000_0000_0000},
        '{8'hC0, -32'sd1,          1, 48'hC000_0000_0000},
        '{8'h8F, 32'sh8000_0000,   1, 48'h8F00_0000_0000},
        '{8'h01, 32'sh7FFF_FFFF,   1, 48'h0100_0000_0000},
        '{8'hAA, 32'sd9,           0, 48'h0},
        '{8'h55, 32'sd10,          0, 48'h0},
        '{8'hC3, 32'sd99,          0, 48'h0},
        '{8'h3C, 32'sd100,         0, 48'h0},
        '{8'hF0, 32'sd999,         0, 48'h0},
        '{8'h0F, 32'sd1000,        0, 48'h0},
        '{8'h81, 32'sd9999,        0, 48'h0},
        '{8'h7E, 32'sd10000,       0, 48'h0},
        '{8'hC5, 32'sd12345,       0, 48'h0},
        '{8'h80, 32'sd99998,       0, 48'h0},
        '{8'h10, 32'sd131071,      0, 48'h0},
        '{8'h08, -32'sd100000,     0, 48'h0}
    };

    char_lcd_decimal_number_writer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_position   (s_position),
        .s_number     (s_number),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_nibble     (m_nibble),
        .m_reg_select (m_reg_select),
        .m_high_half  (m_high_half),
        .m_last       (m_last)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // one byte goes out as upper then lower nibble
    task automatic push_lcd_byte(input logic [7:0] value, input logic rs);
        expected_transfers.push_back('{value[7:4], rs, 1'b1, 1'b0});
        expected_transfers.push_back('{value[3:0], rs, 1'b0, 1'b0});
    endtask

    // position command, then ascii digits without leading zeros
    task automatic predict_lcd_transfers(input logic [7:0] pos,
                                         input logic signed [31:0] num);
        int unsigned value;
        int unsigned digit_buf [5];
        int          n;
        value = num;
        n = 0;
        push_lcd_byte(pos, 1'b0);
        if (num >= 0 && num < DIGIT_LIMIT) begin
            do begin
                digit_buf[n] = value % 10;
                value = value / 10;
                n++;
            end while (value != 0 && n < 5);
            for (int i = n - 1; i >= 0; i--) begin
                push_lcd_byte(8'h30 + digit_buf[i][7:0], 1'b1);
            end
        end
    endtask

    // mostly short gaps, a few long ones, none while calm
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // number mix: digit lengths of 1 to 5, edges, negatives, too large
    function automatic logic signed [31:0] random_number();
        int          kind;
        int          len;
        int unsigned lo;
        int unsigned hi;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            len = $urandom_range(1, 5);
            lo = (len == 1) ? 0 : 10 ** (len - 1);
            hi = 10 ** len - 1;
            return $urandom_range(hi, lo);
        end
        if (kind < 75) begin
            case ($urandom_range(0, 2))
                0: return 32'sd0;
                1: return 32'sd99999;
                default: return 32'sd100000;
            endcase
        end
        if (kind < 85) return $urandom | 32'h8000_0000;
        if (kind < 95) return $urandom_range(32'h7FFF_FFFF, DIGIT_LIMIT);
        return $urandom;
    endfunction

    // present one request, called at a falling edge, returns at a falling edge
    task automatic send_request(input logic [7:0] pos, input logic signed [31:0] num,
                                input int byte_count, input logic [47:0] byte_list);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_position <= pos;
        s_number   <= num;
        do @(posedge aclk); while (!s_ready);
        if (byte_count == 0) begin
            predict_lcd_transfers(pos, num);
        end else begin
            for (int i = 0; i < byte_count; i++) begin
                push_lcd_byte(byte_list[47 - 8 * i -: 8], i != 0);
            end
        end
        expected_transfers[expected_transfers.size() - 1].last = 1'b1;
        @(negedge aclk);
    endtask

    // hold the sender until the block has nothing left to deliver
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_transfers.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // receiver stalls
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = gap_length();
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        lcd_transfer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_transfers.size() == 0) begin
                report_mismatch($sformatf("nibble %h with no request pending", m_nibble));
            end else begin
                want = expected_transfers.pop_front();
                if (m_nibble !== want.nibble)
                    report_mismatch($sformatf("nibble %h, want %h", m_nibble, want.nibble));
                if (m_reg_select !== want.reg_select)
                    report_mismatch($sformatf("reg_select %b, want %b",
                                              m_reg_select, want.reg_select));
                if (m_high_half !== want.high_half)
                    report_mismatch($sformatf("high_half %b, want %b",
                                              m_high_half, want.high_half));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_last, want.last));
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_position = 8'h00;
        s_number   = 32'sd0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(directed_rows[i].position, directed_rows[i].number,
                         directed_rows[i].byte_count, directed_rows[i].byte_list);
        end
        drain_results();

        // random requests, one stretch with no gaps, one full drain midway
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 60 && i < 90);
            if (i == 120) drain_results();
            send_request(8'($urandom_range(0, 255)), random_number(), 0, 48'h0);
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (expected_transfers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_transfers.size() != 0)
            report_mismatch($sformatf("%0d nibbles never arrived", expected_transfers.size()));

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/cldn_pkg.sv
hw/rtl/cldn_datapath.sv
hw/rtl/cldn_ctrl.sv
hw/rtl/char_lcd_decimal_number_writer.sv
bench/char_lcd_decimal_number_writer_test.sv
